// ----- src/tlb_pkg.sv -----
`default_nettype none
package tlb_pkg;

  // Field and datapath widths
  localparam int READ_W    = 12;
  localparam int QF_W      = 16;
  localparam int CF_W      = 12;
  localparam int CUT_W     = 13;
  localparam int OUT_W     = 18;
  localparam int HIST_W    = 26;
  localparam int COEF_W    = 32;
  localparam int TRIG_W    = 32;
  localparam int MUL_W     = 33;
  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 34;

  // Register reset values and limits
  localparam logic [QF_W-1:0]  QF_RESET   = 16'd2896;
  localparam logic [QF_W-1:0]  QF_MIN     = 16'd205;
  localparam logic [CF_W-1:0]  CF_RESET   = 12'd82;
  localparam logic [CUT_W-1:0] CUT_RESET  = 13'd1600;
  localparam logic [CUT_W-1:0] CUT_MIN    = 13'd16;
  localparam logic [CUT_W-1:0] CUT_MAX    = 13'd6400;

  // Trig constants in Q28
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd163008219;
  localparam logic signed [TRIG_W-1:0] HALF_PI_Q28 = 32'sd421657428;
  localparam logic signed [TRIG_W-1:0] PI_Q28      = 32'sd843314857;
  localparam logic [18:0]              LOG2_200_Q16 = 19'd500948;

  // Fixed divides done by reciprocal multiplication
  // e = ((raw * LOG2_200_Q16 + 2047) * RECIP_4095) >> 43, exact for every raw
  localparam logic [31:0] RECIP_4095  = 32'd2148008065;
  localparam logic [31:0] POT_ROUND   = 32'd2047;
  // 2*pi in Q28 is 16000 * ANGLE_WHOLE + ANGLE_FRAC; the fraction part is
  // ((cut * ANGLE_FRAC + 8000) >> 7) * RECIP_125 >> 26
  localparam logic [16:0] ANGLE_WHOLE = 17'd105414;
  localparam logic [12:0] ANGLE_FRAC  = 13'd5713;
  localparam logic [25:0] ANGLE_ROUND = 26'd8000;
  localparam logic [19:0] RECIP_125   = 20'd536871;

  typedef struct packed {
    logic signed [TRIG_W-1:0] x;
    logic signed [TRIG_W-1:0] y;
  } trig_t;

  // Arctangent of 2^-i in Q28
  function automatic logic signed [TRIG_W-1:0] atan_step(input logic [4:0] i);
    logic signed [TRIG_W-1:0] r;
    unique case (i)
      5'd0: r = 32'sd210828714;
      5'd1: r = 32'sd124459457;
      5'd2: r = 32'sd65760959;
      5'd3: r = 32'sd33381290;
      5'd4: r = 32'sd16755423;
      5'd5: r = 32'sd8385879;
      5'd6: r = 32'sd4193963;
      5'd7: r = 32'sd2097109;
      5'd8: r = 32'sd1048571;
      5'd9: r = 32'sd524287;
      default: r = (i <= 5'd28) ? (TRIG_W'(1) << (5'd28 - i)) : '0;
    endcase
    return r;
  endfunction

  // Taylor terms of 2^f in Q30
  function automatic logic [31:0] exp2_term(input logic [2:0] k);
    logic [31:0] r;
    unique case (k)
      3'd0: r = 32'd1073741824;
      3'd1: r = 32'd744261118;
      3'd2: r = 32'd257941248;
      3'd3: r = 32'd59597083;
      3'd4: r = 32'd10327388;
      3'd5: r = 32'd1431680;
      3'd6: r = 32'd165394;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/tunable_lowpass_biquad.sv -----
`default_nettype none
// channel  | handshake                  | payload
// item     | item_valid / item_ready    | action, reading
// result   | result_valid / result_ready| filtered_sample, retuned, cutoff_now
// config   | cfg_write (no wait)        | cfg_index, cfg_data
//
// A sample runs five taps through the one shared multiplier, then rounding.
// A pot item: two multiplies map the reading, then six Horner steps form the cutoff.
// A retune adds three angle multiplies, a CORDIC rotation and five runs of the 64-bit
// bit-serial divider (alpha, coefficients).
// After reset item_ready stays low while the coefficients for CUT_RESET are set up.
// A finished result waits in the output register while the next item is taken.
module tunable_lowpass_biquad import tlb_pkg::*; #(
  parameter int SAMPLE_BITS    = 12,
  parameter int COEF_FRAC_BITS = 28,
  parameter int CORDIC_STEPS   = 24
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    item_valid,
  output logic                         item_ready,
  input  wire logic                    action,
  input  wire logic [READ_W-1:0]       reading,
  output logic                         result_valid,
  input  wire logic                    result_ready,
  output logic signed [OUT_W-1:0]      filtered_sample,
  output logic                         retuned,
  output logic [CUT_W-1:0]             cutoff_now,
  input  wire logic                    cfg_write,
  input  wire logic                    cfg_index,
  input  wire logic [QF_W-1:0]         cfg_data
);

  localparam logic REG_QUALITY = 1'b0;
  localparam logic REG_CHANGE  = 1'b1;

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_MAC    = 5'd1;
  localparam logic [4:0] ST_SFIN   = 5'd2;
  localparam logic [4:0] ST_PMUL   = 5'd3;
  localparam logic [4:0] ST_PRCP   = 5'd4;
  localparam logic [4:0] ST_DIVW   = 5'd5;
  localparam logic [4:0] ST_PHINIT = 5'd6;
  localparam logic [4:0] ST_HORN   = 5'd7;
  localparam logic [4:0] ST_HACC   = 5'd8;
  localparam logic [4:0] ST_PFIN   = 5'd9;
  localparam logic [4:0] ST_CMPM   = 5'd10;
  localparam logic [4:0] ST_CMP    = 5'd11;
  localparam logic [4:0] ST_TMUL   = 5'd12;
  localparam logic [4:0] ST_TRCP   = 5'd13;
  localparam logic [4:0] ST_TFOLD  = 5'd14;
  localparam logic [4:0] ST_CORW   = 5'd15;
  localparam logic [4:0] ST_ADIVGO = 5'd16;
  localparam logic [4:0] ST_ALAT   = 5'd17;
  localparam logic [4:0] ST_QGO    = 5'd18;
  localparam logic [4:0] ST_QLAT   = 5'd19;
  localparam logic [4:0] ST_DONE   = 5'd20;
  localparam logic [4:0] ST_TWHOLE = 5'd21;

  localparam logic signed [63:0] HIST_MAX = 64'sd33554431;
  localparam logic signed [63:0] HIST_MIN = -64'sd33554432;
  localparam logic signed [26:0] OUT_MAX  = 27'sd131071;
  localparam logic signed [26:0] OUT_MIN  = -27'sd131072;
  localparam logic signed [34:0] TRIG_ONE = 35'sd268435456;
  localparam logic signed [63:0] COEF_MAX = 64'sd2147483647;
  localparam logic signed [63:0] COEF_MIN = -64'sd2147483648;

  // Control
  logic [4:0] state, ret;
  logic       boot;
  logic [2:0] k, hk;
  logic [1:0] ci;

  // Registers and coefficients
  logic [QF_W-1:0]          quality, q_lat;
  logic [CF_W-1:0]          change;
  logic signed [COEF_W-1:0] coef_b0, coef_b1, coef_b2, coef_fb1, coef_fb2;
  logic [SAMPLE_BITS-1:0]   x_cur, x_hist0, x_hist1;
  logic signed [HIST_W-1:0] y_hist0, y_hist1;
  logic [CUT_W-1:0]         prev_cut, active_cut, cut, fc;

  // Datapath
  logic [READ_W-1:0]            raw;
  logic signed [63:0]           acc;
  logic signed [MUL_W-1:0]      mul_a, mul_b;
  logic signed [2*MUL_W-1:0]    prod;
  logic [3:0]                   e_ip;
  logic [29:0]                  xh;
  logic [31:0]                  p;
  logic [11:0]                  th_frac;
  logic                         flip, q_neg;
  logic [DIV_DEN_W-1:0]         alpha, a0;
  logic signed [TRIG_W-1:0]     xf;
  logic signed [OUT_W-1:0]      res_sample;
  logic                         res_retuned;

  // Shared units
  logic                         div_start, div_done;
  logic [DIV_NUM_W-1:0]         div_numer, div_quot;
  logic [DIV_DEN_W-1:0]         div_denom;
  logic                         cor_start, cor_done;
  logic signed [TRIG_W-1:0]     cor_theta;
  trig_t                        cor_res;

  // Combinational temporaries
  logic [READ_W+SAMPLE_BITS-1:0] read_ext;
  logic signed [63:0]            acc_rnd, y_full;
  logic signed [HIST_W-1:0]      y_sat;
  logic signed [26:0]            o_sum, o_shift;
  logic signed [OUT_W-1:0]       o_sat;
  logic [51:0]                   p_sh;
  logic [21:0]                   v;
  logic [CUT_W-1:0]              fc_next, base, cut_delta;
  logic [25:0]                   ang_sum;
  logic signed [TRIG_W-1:0]      th_raw;
  logic signed [34:0]            nval;
  logic signed [63:0]            n_full, qs;
  logic [63:0]                   n_mag;
  logic [DIV_DEN_W-1:0]          half;
  logic signed [COEF_W-1:0]      coef_sat;
  logic                          retune_hit;

  assign item_ready = (state == ST_IDLE);
  assign read_ext   = (READ_W + SAMPLE_BITS)'(reading);

  // Filter rounding and output saturation
  always_comb begin
    acc_rnd = acc + (64'sd1 <<< (COEF_FRAC_BITS - 1));
    y_full  = acc_rnd >>> COEF_FRAC_BITS;
    if (y_full > HIST_MAX)      y_sat = HIST_W'(HIST_MAX);
    else if (y_full < HIST_MIN) y_sat = HIST_W'(HIST_MIN);
    else                        y_sat = HIST_W'(y_full);
    o_sum   = 27'(y_sat) + 27'sd128;
    o_shift = o_sum >>> 8;
    if (o_shift > OUT_MAX)      o_sat = OUT_W'(OUT_MAX);
    else if (o_shift < OUT_MIN) o_sat = OUT_W'(OUT_MIN);
    else                        o_sat = OUT_W'(o_shift);
  end

  // Pot mapping, retune test and angle assembly
  always_comb begin
    p_sh = 52'(p) << (5'(e_ip) + 5'd5);
    v    = 22'((p_sh + (52'd1 << 29)) >> 30);
    if (v < 22'(CUT_MIN))      fc_next = CUT_MIN;
    else if (v > 22'(CUT_MAX)) fc_next = CUT_MAX;
    else                       fc_next = v[CUT_W-1:0];
    base       = (prev_cut != '0) ? prev_cut : fc;
    cut_delta  = (fc > prev_cut) ? fc - prev_cut : prev_cut - fc;
    retune_hit = !({cut_delta, 12'b0} < prod[24:0]);
    ang_sum    = prod[25:0] + ANGLE_ROUND;
    th_raw     = signed'({2'b00, prod[29:0]} + TRIG_W'(th_frac));
  end

  // Coefficient numerators and rounding
  always_comb begin
    unique case (ci)
      2'd0, 2'd1: nval = TRIG_ONE - 35'(xf);
      2'd2:       nval = 35'(xf) <<< 1;
      2'd3:       nval = $signed({1'b0, alpha}) - TRIG_ONE;
      default:    nval = '0;
    endcase
    n_full = 64'(nval) <<< COEF_FRAC_BITS;
    n_mag  = n_full[63] ? 64'(-n_full) : 64'(n_full);
    half   = (ci == 2'd0) ? a0 : (a0 >> 1);
    qs     = q_neg ? -signed'(div_quot) : signed'(div_quot);
    if (qs > COEF_MAX)      coef_sat = COEF_W'(COEF_MAX);
    else if (qs < COEF_MIN) coef_sat = COEF_W'(COEF_MIN);
    else                    coef_sat = COEF_W'(qs);
  end

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_MAC: begin
        unique case (k)
          3'd0: begin mul_a = MUL_W'(coef_b0);  mul_b = MUL_W'(x_cur);   end
          3'd1: begin mul_a = MUL_W'(coef_b1);  mul_b = MUL_W'(x_hist0); end
          3'd2: begin mul_a = MUL_W'(coef_b2);  mul_b = MUL_W'(x_hist1); end
          3'd3: begin mul_a = MUL_W'(coef_fb1); mul_b = MUL_W'(y_hist0); end
          3'd4: begin mul_a = MUL_W'(coef_fb2); mul_b = MUL_W'(y_hist1); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      ST_HORN: begin mul_a = MUL_W'(p);       mul_b = MUL_W'(xh);           end
      ST_PMUL: begin mul_a = MUL_W'(raw);     mul_b = MUL_W'(LOG2_200_Q16); end
      ST_PRCP: begin
        mul_a = MUL_W'({1'b0, prod[30:0]} + POT_ROUND);
        mul_b = MUL_W'(RECIP_4095);
      end
      ST_CMPM:   begin mul_a = MUL_W'(change); mul_b = MUL_W'(base);         end
      ST_TMUL:   begin mul_a = MUL_W'(cut);    mul_b = MUL_W'(ANGLE_FRAC);   end
      ST_TRCP:   begin mul_a = MUL_W'(ang_sum[25:7]); mul_b = MUL_W'(RECIP_125); end
      ST_TWHOLE: begin mul_a = MUL_W'(cut);    mul_b = MUL_W'(ANGLE_WHOLE);  end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Divider and CORDIC launch
  always_comb begin
    div_start = 1'b0;
    div_numer = '0;
    div_denom = '0;
    unique case (state)
      ST_ADIVGO: begin
        div_start = 1'b1;
        div_numer = cor_res.y[TRIG_W-1] ? '0 : (64'(cor_res.y) << 11);
        div_denom = DIV_DEN_W'(q_lat);
      end
      ST_QGO: begin
        div_start = 1'b1;
        div_numer = n_mag + 64'(half);
        div_denom = (ci == 2'd0) ? {a0[DIV_DEN_W-2:0], 1'b0} : a0;
      end
      default: div_start = 1'b0;
    endcase
    cor_start = (state == ST_TFOLD);
    cor_theta = (th_raw > HALF_PI_Q28) ? PI_Q28 - th_raw : th_raw;
  end

  tlb_divider #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (div_numer),
    .denom (div_denom),
    .done  (div_done),
    .quot  (div_quot)
  );

  tlb_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .theta (cor_theta),
    .done  (cor_done),
    .res   (cor_res)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      quality <= QF_RESET;
      change  <= CF_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_QUALITY: quality <= cfg_data;
        REG_CHANGE:  change  <= cfg_data[CF_W-1:0];
        default:     change  <= change;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_TMUL;
      ret          <= ST_IDLE;
      boot         <= 1'b1;
      cut          <= CUT_RESET;
      q_lat        <= QF_RESET;
      prev_cut     <= '0;
      active_cut   <= CUT_RESET;
      x_hist0      <= '0;
      x_hist1      <= '0;
      y_hist0      <= '0;
      y_hist1      <= '0;
      result_valid <= 1'b0;
      k            <= '0;
      hk           <= '0;
      ci           <= '0;
    end else begin
      if (result_valid && result_ready && state != ST_DONE) result_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (item_valid) begin
            raw   <= reading;
            x_cur <= read_ext[SAMPLE_BITS-1:0];
            acc   <= '0;
            k     <= '0;
            state <= action ? ST_PMUL : ST_MAC;
          end
        end
        // Five taps; accumulate the product of the previous tap
        ST_MAC: begin
          if (k != 3'd0) acc <= acc + ((k <= 3'd3) ? (64'(prod) <<< 12) : 64'(prod));
          k <= k + 1'b1;
          if (k == 3'd5) state <= ST_SFIN;
        end
        ST_SFIN: begin
          x_hist1     <= x_hist0;
          x_hist0     <= x_cur;
          y_hist1     <= y_hist0;
          y_hist0     <= y_sat;
          res_sample  <= o_sat;
          res_retuned <= 1'b0;
          state       <= ST_DONE;
        end
        ST_PMUL: state <= ST_PRCP;
        ST_PRCP: state <= ST_PHINIT;
        ST_DIVW: begin
          if (div_done) state <= ret;
        end
        // Split the log value e = prod >> 43 into integer and fraction
        ST_PHINIT: begin
          e_ip  <= prod[62:59];
          xh    <= {prod[58:43], 14'b0};
          p     <= exp2_term(3'd6);
          hk    <= 3'd5;
          state <= ST_HORN;
        end
        ST_HORN: state <= ST_HACC;
        ST_HACC: begin
          p <= exp2_term(hk) + 32'(prod >>> 30);
          if (hk == 3'd0) begin
            state <= ST_PFIN;
          end else begin
            hk    <= hk - 1'b1;
            state <= ST_HORN;
          end
        end
        ST_PFIN: begin
          fc    <= fc_next;
          state <= ST_CMPM;
        end
        ST_CMPM: state <= ST_CMP;
        ST_CMP: begin
          res_sample <= '0;
          if (retune_hit) begin
            prev_cut    <= fc;
            active_cut  <= fc;
            cut         <= fc;
            q_lat       <= (quality < QF_MIN) ? QF_MIN : quality;
            res_retuned <= 1'b1;
            state       <= ST_TMUL;
          end else begin
            res_retuned <= 1'b0;
            state       <= ST_DONE;
          end
        end
        // Coefficient computation; clear the delay line
        ST_TMUL: begin
          x_hist0 <= '0;
          x_hist1 <= '0;
          y_hist0 <= '0;
          y_hist1 <= '0;
          state   <= ST_TRCP;
        end
        ST_TRCP: state <= ST_TWHOLE;
        // Hold the fraction part of the angle while the whole part is formed
        ST_TWHOLE: begin
          th_frac <= prod[37:26];
          state   <= ST_TFOLD;
        end
        ST_TFOLD: begin
          flip  <= th_raw > HALF_PI_Q28;
          state <= ST_CORW;
        end
        ST_CORW: begin
          if (cor_done) state <= ST_ADIVGO;
        end
        ST_ADIVGO: begin
          ret   <= ST_ALAT;
          state <= ST_DIVW;
        end
        ST_ALAT: begin
          alpha <= div_quot[DIV_DEN_W-1:0];
          a0    <= DIV_DEN_W'(TRIG_ONE) + div_quot[DIV_DEN_W-1:0];
          xf    <= flip ? -cor_res.x : cor_res.x;
          ci    <= '0;
          state <= ST_QGO;
        end
        ST_QGO: begin
          q_neg <= n_full[63];
          ret   <= ST_QLAT;
          state <= ST_DIVW;
        end
        ST_QLAT: begin
          unique case (ci)
            2'd0: begin coef_b0 <= coef_sat; coef_b2 <= coef_sat; end
            2'd1: coef_b1  <= coef_sat;
            2'd2: coef_fb1 <= coef_sat;
            2'd3: coef_fb2 <= coef_sat;
            default: coef_fb2 <= coef_fb2;
          endcase
          if (ci == 2'd3) begin
            boot  <= 1'b0;
            state <= boot ? ST_IDLE : ST_DONE;
          end else begin
            ci    <= ci + 1'b1;
            state <= ST_QGO;
          end
        end
        // Hand the item to the output register
        ST_DONE: begin
          if (!result_valid || result_ready) begin
            filtered_sample <= res_sample;
            retuned         <= res_retuned;
            cutoff_now      <= active_cut;
            result_valid    <= 1'b1;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_retune_no_sample: assert property (@(posedge clk) disable iff (rst)
    result_valid && retuned |-> filtered_sample == '0)
    else $error("retuned item carries a filter output");

  a_cut_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> cutoff_now >= CUT_MIN && cutoff_now <= CUT_MAX)
    else $error("cutoff out of range");

  a_boot_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !boot)
    else $error("idle before boot coefficients are ready");

  a_cut_track: assert property (@(posedge clk) disable iff (rst)
    prev_cut != '0 |-> prev_cut == active_cut)
    else $error("active cutoff differs from last retune");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIVW)
    else $error("divider finished outside its wait state");

endmodule
`default_nettype wire

// ----- src/tlb_divider.sv -----
`default_nettype none
module tlb_divider #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 34
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] numer,
  input  wire logic [DEN_W-1:0] denom,
  output logic                  done,
  output logic [NUM_W-1:0]      quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [CNT_W-1:0] count;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic             fits;

  // One quotient bit per cycle, restoring
  assign trial = {rem, quot[NUM_W-1]};
  assign fits  = trial >= {1'b0, den};

  // Count iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(NUM_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      den  <= denom;
      quot <= numer;
    end else if (busy) begin
      rem  <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      quot <= {quot[NUM_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// ----- src/tlb_cordic.sv -----
`default_nettype none
module tlb_cordic import tlb_pkg::*; #(
  parameter int STEPS = 24
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic signed [TRIG_W-1:0] theta,
  output logic                          done,
  output trig_t                         res
);

  localparam int IDX_W = $clog2(STEPS);

  logic [IDX_W-1:0]         iter;
  logic                     busy;
  logic signed [TRIG_W-1:0] xr, yr, th;
  logic signed [TRIG_W-1:0] dx, dy, step;

  assign dx   = yr >>> iter;
  assign dy   = xr >>> iter;
  assign step = atan_step(5'(iter));
  assign res  = '{x: xr, y: yr};

  // Sequence the rotations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
      end else if (busy) begin
        iter <= iter + 1'b1;
        if (iter == IDX_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Rotate toward zero residual angle
  always_ff @(posedge clk) begin
    if (start) begin
      xr <= CORDIC_GAIN;
      yr <= '0;
      th <= theta;
    end else if (busy) begin
      if (th >= 0) begin
        xr <= xr - dx;
        yr <= yr + dy;
        th <= th - step;
      end else begin
        xr <= xr + dx;
        yr <= yr - dy;
        th <= th + step;
      end
    end
  end

endmodule
`default_nettype wire
